// ===== rtl/lda_pkg.sv =====
// ----------------------------------------------------------------------------
// Log-domain add/subtract package
// Shared widths, action and register codes, and the correction table builder.
// ----------------------------------------------------------------------------
package lda_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TABLE_BITS = 10;
  localparam int SPAN_BITS  = 5;
  localparam int TAB_SIZE   = 1 << TABLE_BITS;
  localparam int DATA_W     = 32;
  localparam int WIDE_W     = DATA_W + 1;
  localparam int SUM_W      = DATA_W + 2;
  localparam int IDX_SH     = FRAC_BITS + SPAN_BITS - TABLE_BITS;
  localparam int IDX_SH_R   = (IDX_SH > 0) ? IDX_SH : 0;
  localparam int IDX_SH_L   = (IDX_SH < 0) ? -IDX_SH : 0;

  localparam int    SERIES_TERMS = 24;
  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam longint LN2_Q30     = 64'sd744261118;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_SUB     = 2'd1,
    ACT_LOG_ADD = 2'd2,
    ACT_LOG_SUB = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_LOG_ZERO    = 2'd0,
    REG_LOG_SMALL   = 2'd1,
    REG_MIN_LOG_EXP = 2'd2
  } cfg_reg_t;

  localparam logic signed [DATA_W-1:0] LOG_ZERO_RST    = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] LOG_SMALL_RST   = 32'shC000_0000;
  localparam logic signed [DATA_W-1:0] MIN_LOG_EXP_RST = -32'sd1509022;

  // Decoded work for one item, handed from the decode logic to the final adder.
  typedef struct packed {
    logic signed [WIDE_W-1:0] base;
    logic                     use_rom;
    logic                     sub_sel;
    logic                     force_zero;
    logic                     err;
  } prep_t;

  // Signed quotient rounded toward zero, by shift and subtract. Only the
  // table builder uses it, so it runs at elaboration.
  function automatic longint div_trunc(input longint num, input longint den);
    logic [63:0] n_mag;
    logic [63:0] d_mag;
    logic [63:0] quo;
    logic [63:0] rem;
    logic        neg;
    begin
      neg   = (num < 0) != (den < 0);
      n_mag = (num < 0) ? 64'(-num) : 64'(num);
      d_mag = (den < 0) ? 64'(-den) : 64'(den);
      quo   = '0;
      rem   = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], n_mag[b]};
        if (rem >= d_mag) begin
          rem    = rem - d_mag;
          quo[b] = 1'b1;
        end
      end
      div_trunc = neg ? -longint'(quo) : longint'(quo);
    end
  endfunction

  // exp(-t) in Q30, t in Q30.
  function automatic longint exp_neg_q30(input longint t);
    longint k;
    longint r;
    longint sum;
    longint term;
    begin
      k    = div_trunc(t, LN2_Q30);
      r    = t - k * LN2_Q30;
      sum  = Q30_ONE;
      term = Q30_ONE;
      if (k > 40) begin
        exp_neg_q30 = 0;
      end else begin
        for (int n = 1; n <= SERIES_TERMS; n++) begin
          term = div_trunc(div_trunc(term * r, Q30_ONE), longint'(n));
          sum  = sum + term;
        end
        exp_neg_q30 = div_trunc(64'sd1 <<< 60, sum) >>> k;
      end
    end
  endfunction

  // Natural log in Q30 of a Q30 value.
  function automatic longint ln_q30(input longint v_in);
    longint v;
    longint k;
    longint s;
    longint s2;
    longint term;
    longint acc;
    begin
      v   = (v_in <= 0) ? 64'sd1 : v_in;
      k   = 0;
      acc = 0;
      while (v >= 2 * Q30_ONE) begin
        v = v >>> 1;
        k = k + 1;
      end
      while (v < Q30_ONE) begin
        v = v <<< 1;
        k = k - 1;
      end
      s    = div_trunc((v - Q30_ONE) <<< 30, v + Q30_ONE);
      s2   = (s * s) >>> 30;
      term = s;
      for (int n = 0; n < SERIES_TERMS; n++) begin
        acc  = acc + div_trunc(term, longint'(2 * n + 1));
        term = (term * s2) >>> 30;
      end
      ln_q30 = 2 * acc + k * LN2_Q30;
    end
  endfunction

  // Q30 to FRAC_BITS fraction bits, halves rounded away from zero.
  function automatic longint q30_to_frac(input longint q);
    longint half;
    begin
      half = 64'sd1 <<< (30 - FRAC_BITS - 1);
      if (q >= 0) begin
        q30_to_frac = (q + half) >>> (30 - FRAC_BITS);
      end else begin
        q30_to_frac = -((-q + half) >>> (30 - FRAC_BITS));
      end
    end
  endfunction

  // Table entry i: ln(1+exp(-t)) or ln(1-exp(-t)) at the midpoint of bin i.
  function automatic logic signed [DATA_W-1:0] rom_value(input int idx, input logic is_sub);
    longint t;
    longint e;
    longint q;
    begin
      t = longint'(2 * idx + 1) <<< (34 - TABLE_BITS);
      e = exp_neg_q30(t);
      q = is_sub ? q30_to_frac(ln_q30(Q30_ONE - e)) : q30_to_frac(ln_q30(Q30_ONE + e));
      rom_value = q[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/log_domain_add_sub_unit_top.sv =====
// ----------------------------------------------------------------------------
// Log-domain add/subtract unit, top level
// The input, the decoded work and the result are each registered on the way to out_tvalid.
// Throughput: one item per cycle; the pipeline stalls only while out_tready is low.
// The table read port is registered and sits between decode and the final add.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
module log_domain_add_sub_unit_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [63:0]                       in_tdata,   // x_val[31:0], y_val[63:32]
  input  logic [1:0]                        in_tuser,   // action[1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // result_val[31:0]
  output logic [0:0]                        out_tuser,  // domain_error[0]
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [31:0]                       cfg_data
);

  logic signed [lda_pkg::DATA_W-1:0] log_zero_r;
  logic signed [lda_pkg::DATA_W-1:0] log_small_r;
  logic signed [lda_pkg::DATA_W-1:0] min_log_exp_r;

  logic                              s1_valid_r;
  lda_pkg::action_t                  s1_action_r;
  logic signed [lda_pkg::DATA_W-1:0] s1_x_r;
  logic signed [lda_pkg::DATA_W-1:0] s1_y_r;

  logic                              s2_valid_r;
  lda_pkg::prep_t                    s2_prep_r;

  logic                              out_valid_r;
  logic signed [lda_pkg::DATA_W-1:0] out_result_r;
  logic                              out_err_r;

  lda_pkg::prep_t                    prep_nxt;
  logic [lda_pkg::TABLE_BITS-1:0]    rom_idx;
  logic signed [lda_pkg::DATA_W-1:0] add_corr;
  logic signed [lda_pkg::DATA_W-1:0] sub_corr;
  logic signed [lda_pkg::DATA_W-1:0] result_nxt;

  logic en_out;
  logic en_s2;
  logic en_s1;

  // Each stage loads when it is empty or its contents move on.
  assign en_out    = !out_valid_r || out_tready;
  assign en_s2     = !s2_valid_r || en_out;
  assign en_s1     = !s1_valid_r || en_s2;
  assign in_tready = en_s1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_zero_r    <= lda_pkg::LOG_ZERO_RST;
      log_small_r   <= lda_pkg::LOG_SMALL_RST;
      min_log_exp_r <= lda_pkg::MIN_LOG_EXP_RST;
    end else if (cfg_valid) begin
      case (lda_pkg::cfg_reg_t'(cfg_index))
        lda_pkg::REG_LOG_ZERO:    log_zero_r    <= cfg_data;
        lda_pkg::REG_LOG_SMALL:   log_small_r   <= cfg_data;
        lda_pkg::REG_MIN_LOG_EXP: min_log_exp_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_s1) begin
        s1_valid_r <= in_tvalid;
      end
      if (en_s2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en_out) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1 && in_tvalid) begin
      s1_action_r <= lda_pkg::action_t'(in_tuser);
      s1_x_r      <= in_tdata[31:0];
      s1_y_r      <= in_tdata[63:32];
    end
    if (en_s2) begin
      s2_prep_r <= prep_nxt;
    end
    if (en_out) begin
      out_result_r <= result_nxt;
      out_err_r    <= s2_prep_r.err;
    end
  end

  lda_prep u_prep (
    .action      (s1_action_r),
    .x_val       (s1_x_r),
    .y_val       (s1_y_r),
    .min_log_exp (min_log_exp_r),
    .prep        (prep_nxt),
    .rom_idx     (rom_idx)
  );

  lda_rom u_rom (
    .clk        (clk),
    .rd_en      (en_s2),
    .rd_idx     (rom_idx),
    .add_corr_r (add_corr),
    .sub_corr_r (sub_corr)
  );

  lda_finish u_finish (
    .prep       (s2_prep_r),
    .add_corr   (add_corr),
    .sub_corr   (sub_corr),
    .log_zero   (log_zero_r),
    .log_small  (log_small_r),
    .result_val (result_nxt)
  );

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_result_r;
  assign out_tuser[0] = out_err_r;

endmodule

// ===== rtl/lda_prep.sv =====
// ----------------------------------------------------------------------------
// Log-domain add/subtract decode
// Compares the operands, picks the base value and forms the table index.
// ----------------------------------------------------------------------------
module lda_prep (
  input  lda_pkg::action_t                       action,
  input  logic signed [lda_pkg::DATA_W-1:0]      x_val,
  input  logic signed [lda_pkg::DATA_W-1:0]      y_val,
  input  logic signed [lda_pkg::DATA_W-1:0]      min_log_exp,
  output lda_pkg::prep_t                         prep,
  output logic [lda_pkg::TABLE_BITS-1:0]         rom_idx
);

  logic signed [lda_pkg::WIDE_W-1:0] x_w;
  logic signed [lda_pkg::WIDE_W-1:0] y_w;
  logic signed [lda_pkg::WIDE_W-1:0] mle_w;
  logic signed [lda_pkg::WIDE_W-1:0] diff_xy;
  logic signed [lda_pkg::WIDE_W-1:0] diff_yx;
  logic signed [lda_pkg::WIDE_W-1:0] d_add;
  logic signed [lda_pkg::WIDE_W-1:0] d_sel;
  logic        [lda_pkg::WIDE_W-1:0] mag;
  logic        [lda_pkg::SUM_W-1:0]  mag_sh;
  logic                              x_lt_y;

  assign x_w     = lda_pkg::WIDE_W'(x_val);
  assign y_w     = lda_pkg::WIDE_W'(y_val);
  assign mle_w   = lda_pkg::WIDE_W'(min_log_exp);
  assign diff_xy = x_w - y_w;
  assign diff_yx = y_w - x_w;
  assign x_lt_y  = diff_xy[lda_pkg::WIDE_W-1];
  // The distance is always the smaller minus the larger, so it is never positive.
  assign d_add   = x_lt_y ? diff_xy : diff_yx;
  assign d_sel   = (action == lda_pkg::ACT_LOG_ADD) ? d_add : diff_yx;
  assign mag     = lda_pkg::WIDE_W'(-d_sel);

  always_comb begin
    if (lda_pkg::IDX_SH >= 0) begin
      mag_sh = lda_pkg::SUM_W'(mag >> lda_pkg::IDX_SH_R);
    end else if (mag >= lda_pkg::WIDE_W'(lda_pkg::TAB_SIZE)) begin
      mag_sh = lda_pkg::SUM_W'(lda_pkg::TAB_SIZE);
    end else begin
      mag_sh = lda_pkg::SUM_W'(mag) << lda_pkg::IDX_SH_L;
    end
    if (d_sel[lda_pkg::WIDE_W-1] == 1'b0 && mag != '0) begin
      mag_sh = '0;
    end
    if (mag_sh > lda_pkg::SUM_W'(lda_pkg::TAB_SIZE - 1)) begin
      rom_idx = lda_pkg::TABLE_BITS'(lda_pkg::TAB_SIZE - 1);
    end else begin
      rom_idx = mag_sh[lda_pkg::TABLE_BITS-1:0];
    end
  end

  always_comb begin
    prep.base       = x_w;
    prep.use_rom    = 1'b0;
    prep.sub_sel    = 1'b0;
    prep.force_zero = 1'b0;
    prep.err        = 1'b0;
    case (action)
      lda_pkg::ACT_ADD: begin
        prep.base = x_w + y_w;
      end
      lda_pkg::ACT_SUB: begin
        prep.base = diff_xy;
      end
      lda_pkg::ACT_LOG_ADD: begin
        prep.base    = x_lt_y ? y_w : x_w;
        prep.use_rom = !(d_add < mle_w);
      end
      lda_pkg::ACT_LOG_SUB: begin
        prep.sub_sel = 1'b1;
        if (x_lt_y) begin
          prep.err        = 1'b1;
          prep.force_zero = 1'b1;
        end else if (diff_yx < mle_w) begin
          prep.use_rom = 1'b0;
        end else if (diff_yx == '0) begin
          prep.force_zero = 1'b1;
        end else begin
          prep.use_rom = 1'b1;
        end
      end
      default: begin
        prep.base = x_w;
      end
    endcase
  end

endmodule

// ===== rtl/lda_rom.sv =====
// ----------------------------------------------------------------------------
// Log-domain correction tables
// ln(1+exp(-t)) and ln(1-exp(-t)) tables with a registered read port.
// ----------------------------------------------------------------------------
module lda_rom (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic [lda_pkg::TABLE_BITS-1:0]        rd_idx,
  output logic signed [lda_pkg::DATA_W-1:0]     add_corr_r,
  output logic signed [lda_pkg::DATA_W-1:0]     sub_corr_r
);

  logic signed [lda_pkg::DATA_W-1:0] add_mem [lda_pkg::TAB_SIZE];
  logic signed [lda_pkg::DATA_W-1:0] sub_mem [lda_pkg::TAB_SIZE];

  // Contents are worked out at elaboration, one entry per generate block.
  for (genvar gi = 0; gi < lda_pkg::TAB_SIZE; gi++) begin : g_entry
    localparam logic signed [lda_pkg::DATA_W-1:0] ADD_V = lda_pkg::rom_value(gi, 1'b0);
    localparam logic signed [lda_pkg::DATA_W-1:0] SUB_V = lda_pkg::rom_value(gi, 1'b1);
    assign add_mem[gi] = ADD_V;
    assign sub_mem[gi] = SUB_V;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      add_corr_r <= add_mem[rd_idx];
      sub_corr_r <= sub_mem[rd_idx];
    end
  end

endmodule

// ===== rtl/lda_finish.sv =====
// ----------------------------------------------------------------------------
// Log-domain result finish
// Adds the correction, forces small results to log zero and saturates.
// ----------------------------------------------------------------------------
module lda_finish (
  input  lda_pkg::prep_t                       prep,
  input  logic signed [lda_pkg::DATA_W-1:0]    add_corr,
  input  logic signed [lda_pkg::DATA_W-1:0]    sub_corr,
  input  logic signed [lda_pkg::DATA_W-1:0]    log_zero,
  input  logic signed [lda_pkg::DATA_W-1:0]    log_small,
  output logic signed [lda_pkg::DATA_W-1:0]    result_val
);

  localparam logic signed [lda_pkg::SUM_W-1:0] POS_MAX =
    lda_pkg::SUM_W'({1'b0, {(lda_pkg::DATA_W-1){1'b1}}});

  logic signed [lda_pkg::DATA_W-1:0] corr;
  logic signed [lda_pkg::SUM_W-1:0]  sum;

  assign corr = !prep.use_rom ? '0 : (prep.sub_sel ? sub_corr : add_corr);
  assign sum  = lda_pkg::SUM_W'(prep.base) + lda_pkg::SUM_W'(corr);

  always_comb begin
    if (prep.force_zero || sum < lda_pkg::SUM_W'(log_small)) begin
      result_val = log_zero;
    end else if (sum > POS_MAX) begin
      result_val = POS_MAX[lda_pkg::DATA_W-1:0];
    end else begin
      result_val = sum[lda_pkg::DATA_W-1:0];
    end
  end

endmodule

// ===== rtl/lda_checker.sv =====
// ----------------------------------------------------------------------------
// Log-domain add/subtract port checker
// Watches the top-level ports for stall, reset and flow-through behavior.
// ----------------------------------------------------------------------------
module lda_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // With the sink ready, nothing inside can hold the input back.
  a_flow_through: assert property (@(posedge clk)
    rst_n && out_tready |-> in_tready)
    else $error("input stalled while output is ready");

  // An input that is refused can only be refused while a result waits.
  a_stall_cause: assert property (@(posedge clk)
    rst_n && in_tvalid && !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind log_domain_add_sub_unit_top lda_checker u_lda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
